FILE: rtl/core/locm_pkg.sv
// Shared types and constants for the lock order cycle monitor.
// Holds the item structs, opcode and status codes, FSM state type and the
// controller/datapath command and flag structs. No dependencies.
`default_nettype none

package locm_pkg;

   // Default sizes
   localparam int NUM_LOCKS_DEF   = 16;
   localparam int STACK_DEPTH_DEF = 16;

   // Field widths
   localparam int OP_W    = 2;
   localparam int ID_W    = 4;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 5;
   // Compare width for the lock range check (holds any lock count up to 127)
   localparam int RANGE_W = 7;

   // Opcodes
   localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_TOP  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] lock_id;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              cycle_found;
      logic [CNT_W-1:0]  held_count;
   } rsp_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EDGE_WR,
      FSM_POP_LD,
      FSM_REACH,
      FSM_PEEL,
      FSM_RESULT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic              capture;    // latch item, status code
      logic [STAT_W-1:0] status;
      logic              push;
      logic              pop;
      logic              edge_wr;    // write back edge row of old top
      logic              load_top;   // reload top of stack after pop
      logic              init_reach; // start reachability sweep from root
      logic              init_peel;  // start sink peeling on reached set
      logic              sweep;      // sweep counter runs, rows processed
      logic              peel_mode;
      logic              finish;     // latch cycle flag from peel result
      logic              load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_acq;
      logic is_rel;
      logic is_qry;
      logic full;
      logic empty;
      logic in_range;
      logic top_match;
      logic root_valid;
      logic pass_end;
      logic pass_changed;
   } flag_type;

endpackage

`default_nettype wire

FILE: rtl/core/locm_ram.sv
// Generic single write port, single read port RAM with registered read.
// Used for the held stack and the edge matrix rows. No dependencies.
`default_nettype none

module locm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/locm_ctrl.sv
// Controller FSM of the lock order cycle monitor: sequences acquire,
// release and query items and owns the handshakes. Uses locm_pkg.
`default_nettype none

module locm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire locm_pkg::flag_type flags,
   output locm_pkg::cmd_type       cmd
);

   locm_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                sweep_done;

   // A sweep phase ends after a full pass that changed nothing
   assign sweep_done = flags.pass_end && !flags.pass_changed;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         locm_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = locm_pkg::FSM_RESULT;
               if (flags.is_acq && !flags.full && flags.in_range && !flags.empty) begin
                  state_in = locm_pkg::FSM_EDGE_WR;
               end else if (flags.is_rel && !flags.empty && flags.top_match) begin
                  state_in = locm_pkg::FSM_POP_LD;
               end else if (flags.is_qry && flags.root_valid) begin
                  state_in = locm_pkg::FSM_REACH;
               end
            end
         end
         locm_pkg::FSM_EDGE_WR: state_in = locm_pkg::FSM_RESULT;
         locm_pkg::FSM_POP_LD:  state_in = locm_pkg::FSM_RESULT;
         locm_pkg::FSM_REACH: begin
            if (sweep_done) begin
               state_in = locm_pkg::FSM_PEEL;
            end
         end
         locm_pkg::FSM_PEEL: begin
            if (sweep_done) begin
               state_in = locm_pkg::FSM_RESULT;
            end
         end
         locm_pkg::FSM_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = locm_pkg::FSM_IDLE;
            end
         end
         default: state_in = locm_pkg::FSM_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      cmd.status = locm_pkg::STAT_OK;
      unique case (state_ff)
         locm_pkg::FSM_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (flags.is_acq) begin
                  if (flags.full) begin
                     cmd.status = locm_pkg::STAT_OVERFLOW;
                  end else if (flags.in_range) begin
                     cmd.push = 1'b1;
                  end
               end else if (flags.is_rel) begin
                  if (flags.empty) begin
                     cmd.status = locm_pkg::STAT_EMPTY;
                  end else if (!flags.top_match) begin
                     cmd.status = locm_pkg::STAT_NOT_TOP;
                  end else begin
                     cmd.pop = 1'b1;
                  end
               end else if (flags.is_qry) begin
                  cmd.init_reach = flags.root_valid;
               end
            end
         end
         locm_pkg::FSM_EDGE_WR: cmd.edge_wr = 1'b1;
         locm_pkg::FSM_POP_LD:  cmd.load_top = 1'b1;
         locm_pkg::FSM_REACH: begin
            cmd.sweep     = 1'b1;
            cmd.init_peel = sweep_done;
         end
         locm_pkg::FSM_PEEL: begin
            cmd.sweep     = 1'b1;
            cmd.peel_mode = 1'b1;
            cmd.finish    = sweep_done;
         end
         locm_pkg::FSM_RESULT: cmd.load_rsp = !rsp_valid_ff || !rsp_stall;
         default: cmd = '0;
      endcase
   end

   // Output register valid
   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= locm_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != locm_pkg::FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/core/locm_dpath.sv
// Datapath of the lock order cycle monitor: held stack, root, edge rows
// with row valid bits, sweep engine for the cycle query and result register.
// Uses locm_pkg and locm_ram.
`default_nettype none

module locm_dpath #(
   parameter int NumLocks   = locm_pkg::NUM_LOCKS_DEF,
   parameter int StackDepth = locm_pkg::STACK_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire locm_pkg::req_type req_item,
   input  wire locm_pkg::cmd_type cmd,
   output locm_pkg::flag_type     flags,
   output locm_pkg::rsp_type      rsp_item
);

   localparam int LockW = $clog2(NumLocks);
   localparam int StkW  = $clog2(StackDepth);
   localparam int DepW  = $clog2(StackDepth + 1);

   // Stack and graph state
   logic [DepW-1:0]          depth_ff, depth_in;
   logic [locm_pkg::ID_W-1:0] top_ff, top_in;
   logic [locm_pkg::ID_W-1:0] id_ff;
   logic [LockW-1:0]         root_ff;
   logic                     root_valid_ff;
   logic [NumLocks-1:0]      seen_ff;
   logic [NumLocks-1:0]      edge_valid_ff;
   logic [LockW-1:0]         src_ff;
   logic [locm_pkg::STAT_W-1:0] status_ff;
   logic                     cyc_ff, cyc_in;
   locm_pkg::rsp_type        rsp_ff;

   // Sweep engine
   logic [LockW-1:0]    v_ff, pv_ff;
   logic                proc_ff, changed_ff;
   logic [NumLocks-1:0] reach_ff, reach_in, set_ff, set_in;
   logic [NumLocks-1:0] reach_upd, set_upd, row;
   logic                active, chg;

   // Memory ports
   logic [locm_pkg::ID_W-1:0] stk_rdata;
   logic [NumLocks-1:0]       edge_rdata, edge_wdata, old_row;
   logic [LockW-1:0]          edge_raddr;

   logic [LockW-1:0] req_idx, id_idx, top_idx;

   assign req_idx = LockW'(req_item.lock_id);
   assign id_idx  = LockW'(id_ff);
   assign top_idx = LockW'(top_ff);

   // Held stack entries
   locm_ram #(
      .Width (locm_pkg::ID_W),
      .Depth (StackDepth)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (StkW'(depth_ff)),
      .wr_data (req_item.lock_id),
      .rd_addr (StkW'(depth_ff - DepW'(2))),
      .rd_data (stk_rdata)
   );

   // Edge rows: row of the old top is read at accept, written back next cycle
   assign old_row    = edge_valid_ff[src_ff] ? edge_rdata : '0;
   assign edge_wdata = old_row | (NumLocks'(1) << id_idx);
   assign edge_raddr = cmd.sweep ? v_ff : top_idx;

   locm_ram #(
      .Width (NumLocks),
      .Depth (NumLocks)
   ) u_edges (
      .clock   (clock),
      .wr_en   (cmd.edge_wr),
      .wr_addr (src_ff),
      .wr_data (edge_wdata),
      .rd_addr (edge_raddr),
      .rd_data (edge_rdata)
   );

   // Item classification
   always_comb begin
      flags = '0;
      flags.is_acq     = (req_item.op == locm_pkg::OP_ACQUIRE);
      flags.is_rel     = (req_item.op == locm_pkg::OP_RELEASE);
      flags.is_qry     = (req_item.op == locm_pkg::OP_QUERY);
      flags.full       = (depth_ff == DepW'(StackDepth));
      flags.empty      = (depth_ff == '0);
      flags.in_range   = ({{(locm_pkg::RANGE_W - locm_pkg::ID_W){1'b0}}, req_item.lock_id}
                          < locm_pkg::RANGE_W'(NumLocks));
      flags.top_match  = (top_ff == req_item.lock_id);
      flags.root_valid = root_valid_ff;
      flags.pass_end   = proc_ff && (pv_ff == LockW'(NumLocks - 1));
      flags.pass_changed = changed_ff | chg;
   end

   // Row processing: reach grows from reached nodes, peel drops sinks
   always_comb begin
      row       = edge_valid_ff[pv_ff] ? edge_rdata : '0;
      reach_upd = reach_ff[pv_ff] ? (reach_ff | row) : reach_ff;
      set_upd   = set_ff;
      if (set_ff[pv_ff] && ((row & set_ff) == '0)) begin
         set_upd[pv_ff] = 1'b0;
      end
      active = cmd.sweep & proc_ff;
      chg    = active && (cmd.peel_mode ? (set_upd != set_ff) : (reach_upd != reach_ff));
   end

   always_comb begin
      reach_in = reach_ff;
      if (cmd.init_reach) begin
         reach_in = NumLocks'(1) << root_ff;
      end else if (active && !cmd.peel_mode) begin
         reach_in = reach_upd;
      end
      set_in = set_ff;
      if (cmd.init_peel) begin
         set_in = reach_ff;
      end else if (active && cmd.peel_mode) begin
         set_in = set_upd;
      end
   end

   // Stack depth and top of stack
   always_comb begin
      depth_in = depth_ff;
      top_in   = top_ff;
      if (cmd.push) begin
         depth_in = depth_ff + DepW'(1);
         top_in   = req_item.lock_id;
      end else if (cmd.pop) begin
         depth_in = depth_ff - DepW'(1);
      end else if (cmd.load_top) begin
         top_in = stk_rdata;
      end
   end

   always_comb begin
      cyc_in = cyc_ff;
      if (cmd.capture) begin
         cyc_in = 1'b0;
      end else if (cmd.finish) begin
         cyc_in = |set_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         root_valid_ff <= 1'b0;
         seen_ff       <= '0;
         edge_valid_ff <= '0;
         proc_ff       <= 1'b0;
         changed_ff    <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         if (cmd.push) begin
            seen_ff[req_idx] <= 1'b1;
            if (!seen_ff[req_idx] && !root_valid_ff) begin
               root_valid_ff <= 1'b1;
            end
         end
         if (cmd.edge_wr) begin
            edge_valid_ff[src_ff] <= 1'b1;
         end
         if (cmd.init_reach || cmd.init_peel) begin
            proc_ff    <= 1'b0;
            changed_ff <= 1'b0;
         end else if (cmd.sweep) begin
            proc_ff    <= 1'b1;
            changed_ff <= flags.pass_end ? 1'b0 : (changed_ff | chg);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      top_ff   <= top_in;
      reach_ff <= reach_in;
      set_ff   <= set_in;
      cyc_ff   <= cyc_in;
      pv_ff    <= v_ff;
      if (cmd.push && !seen_ff[req_idx] && !root_valid_ff) begin
         root_ff <= req_idx;
      end
      if (cmd.capture) begin
         id_ff     <= req_item.lock_id;
         src_ff    <= top_idx;
         status_ff <= cmd.status;
      end
      if (cmd.init_reach || cmd.init_peel) begin
         v_ff <= '0;
      end else if (cmd.sweep) begin
         v_ff <= (v_ff == LockW'(NumLocks - 1)) ? '0 : v_ff + LockW'(1);
      end
      if (cmd.load_rsp) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.cycle_found <= cyc_ff;
         rsp_ff.held_count  <= locm_pkg::CNT_W'(depth_ff);
      end
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lock_order_cycle_monitor.sv
// Lock order cycle monitor, one item in flight at a time.
// An acquire with locks held adds an edge write, a release that pops adds a top
// reload, and a query with a root runs Pr reachability and then Pp peeling sweep
// passes (Pr 1 to NumLocks, Pp 1 to NumLocks + 1); each pass reads one edge row
// per cycle from the edge RAM port. Next item taken once the result is loaded.
// Synchronous reset; no clearing pass, edge rows use per-row valid bits.
`default_nettype none

module lock_order_cycle_monitor #(
   parameter int NumLocks   = locm_pkg::NUM_LOCKS_DEF,
   parameter int StackDepth = locm_pkg::STACK_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire locm_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output locm_pkg::rsp_type      rsp_item
);

   locm_pkg::cmd_type  cmd;
   locm_pkg::flag_type flags;

   locm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   locm_dpath #(
      .NumLocks   (NumLocks),
      .StackDepth (StackDepth)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .flags    (flags),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

FILE: rtl/core/locm_checker.sv
// Port-level checks for the lock order cycle monitor, bound to the top.
// Uses locm_pkg.
`default_nettype none

module locm_checker #(
   parameter int StackDepth = locm_pkg::STACK_DEPTH_DEF
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire locm_pkg::rsp_type rsp_item
);

   // One item at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted on back-to-back cycles");

   // A new result only appears while the input side is busy with its item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an item in progress");

   // Only a query reports a cycle, and a query is always ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.cycle_found) |-> (rsp_item.status == locm_pkg::STAT_OK))
      else $error("cycle reported with error status");

   // Held count never exceeds the stack depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_item.held_count) <= StackDepth))
      else $error("held count beyond stack depth");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result changed");

endmodule

bind lock_order_cycle_monitor locm_checker #(
   .StackDepth (StackDepth)
) u_locm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

FILE: verif/lock_order_cycle_monitor_checker.sv
// Checker for the lock order cycle monitor: tracks the lock graph and held
// stack from accepted items and compares every result item against it.
// Depends on locm_pkg for the item structs, opcodes and status codes.
module lock_order_cycle_monitor_checker #(
   parameter int NumLocks   = locm_pkg::NUM_LOCKS_DEF,
   parameter int StackDepth = locm_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  locm_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  locm_pkg::rsp_type rsp_item,
   output int                fail_count,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the monitor state
   logic [NumLocks-1:0]       seen_locks;
   logic [NumLocks-1:0]       lock_edges [NumLocks];
   logic [locm_pkg::ID_W-1:0] held_locks [StackDepth];
   logic [locm_pkg::ID_W-1:0] root_lock;
   bit                        root_known;
   int                        held_depth;

   // Results owed by the block, oldest first
   locm_pkg::rsp_type lock_outcomes[$];

   // Locks reachable from node over one or more edges
   function automatic logic [NumLocks-1:0] reach_set(int node);
      logic [NumLocks-1:0] set;
      logic [NumLocks-1:0] grown;
      set = lock_edges[node];
      for (int pass = 0; pass < NumLocks; pass++) begin
         grown = set;
         for (int v = 0; v < NumLocks; v++)
            if (set[v]) grown |= lock_edges[v];
         if (grown == set) break;
         set = grown;
      end
      return set;
   endfunction

   // Any lock in the root's region that can get back to itself
   function automatic logic cycle_reachable();
      logic [NumLocks-1:0] region;
      logic [NumLocks-1:0] loop_back;
      if (!root_known || root_lock >= NumLocks) return 1'b0;
      region = reach_set(root_lock);
      region[root_lock] = 1'b1;
      for (int v = 0; v < NumLocks; v++) begin
         if (region[v]) begin
            loop_back = reach_set(v);
            if (loop_back[v]) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Apply one item to the shadow state and return its result
   function automatic locm_pkg::rsp_type step_lock_graph(locm_pkg::req_type it);
      locm_pkg::rsp_type r;
      r = '0;
      r.status = locm_pkg::STAT_OK;
      case (it.op)
         locm_pkg::OP_ACQUIRE: begin
            if (held_depth >= StackDepth) begin
               r.status = locm_pkg::STAT_OVERFLOW;
            end else if (it.lock_id < NumLocks) begin
               if (!seen_locks[it.lock_id]) begin
                  seen_locks[it.lock_id] = 1'b1;
                  if (!root_known) begin
                     root_known = 1'b1;
                     root_lock  = it.lock_id;
                  end
               end
               if (held_depth > 0) lock_edges[held_locks[held_depth-1]][it.lock_id] = 1'b1;
               held_locks[held_depth] = it.lock_id;
               held_depth++;
            end
         end
         locm_pkg::OP_RELEASE: begin
            if (held_depth == 0) r.status = locm_pkg::STAT_EMPTY;
            else if (held_locks[held_depth-1] != it.lock_id) r.status = locm_pkg::STAT_NOT_TOP;
            else held_depth--;
         end
         locm_pkg::OP_QUERY: begin
            r.cycle_found = cycle_reachable();
         end
         default: ;
      endcase
      r.held_count = locm_pkg::CNT_W'(held_depth);
      return r;
   endfunction

   // Predict on accepted items, compare on accepted results
   always @(posedge clock) begin
      locm_pkg::rsp_type want;
      if (reset) begin
         seen_locks = '0;
         foreach (lock_edges[i]) lock_edges[i] = '0;
         root_lock  = '0;
         root_known = 1'b0;
         held_depth = 0;
         lock_outcomes.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall)
            lock_outcomes.insert(lock_outcomes.size(), step_lock_graph(req_item));
         if (rsp_valid && !rsp_stall) begin
            if (lock_outcomes.size() == 0) begin
               $error("rsp_item: result with no item outstanding, actual %h", rsp_item);
               fail_count++;
            end else begin
               want = lock_outcomes.pop_front();
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
                  fail_count++;
               end
               if (rsp_item.cycle_found !== want.cycle_found) begin
                  $error("cycle_found: expected %0d, actual %0d",
                         want.cycle_found, rsp_item.cycle_found);
                  fail_count++;
               end
               if (rsp_item.held_count !== want.held_count) begin
                  $error("held_count: expected %0d, actual %0d",
                         want.held_count, rsp_item.held_count);
                  fail_count++;
               end
            end
         end
      end
      outstanding = lock_outcomes.size();
   end

endmodule

FILE: verif/lock_order_cycle_monitor_tb.sv
// Testbench top for the lock order cycle monitor: clock, reset, item
// stimulus and result stalls; checking lives in lock_order_cycle_monitor_checker.
// Depends on locm_pkg, the block and the checker.
module lock_order_cycle_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumLocks   = locm_pkg::NUM_LOCKS_DEF;
   localparam int StackDepth = locm_pkg::STACK_DEPTH_DEF;
   localparam int OpW        = locm_pkg::OP_W;
   localparam int IdW        = locm_pkg::ID_W;
   // Opcode the block decodes as a no-op
   localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
   // Ordered phase: rank 0 is the last lock, ranks 1.. are locks 2..NumLocks-2
   localparam int TOP_RANK = NumLocks - 3;
   localparam int DIRECTED_ITEMS = 16;
   localparam int ORDERED_ITEMS  = 500;
   localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + 1300;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   locm_pkg::req_type req_item  = '0;
   logic              rsp_stall = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   locm_pkg::rsp_type rsp_item;
   int                fail_count;
   int                outstanding;

   // Stimulus bookkeeping: locks held as the block sees them, items sent
   logic [IdW-1:0] held_ids[$];
   int             items_sent = 0;
   bit             calm       = 1'b0;

   lock_order_cycle_monitor #(
      .NumLocks  (NumLocks),
      .StackDepth(StackDepth)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   lock_order_cycle_monitor_checker #(
      .NumLocks  (NumLocks),
      .StackDepth(StackDepth)
   ) monitor_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side stalls at random outside the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 17);
   end

   function automatic logic [IdW-1:0] rank_to_lock(int rank);
      return (rank == 0) ? IdW'(NumLocks - 1) : IdW'(rank + 1);
   endfunction

   function automatic int lock_rank(logic [IdW-1:0] id);
      return (id == NumLocks - 1) ? 0 : int'(id) - 1;
   endfunction

   // Drive one item and hold it until the block takes it
   task automatic send_item(input logic [OpW-1:0] op, input logic [IdW-1:0] id);
      locm_pkg::req_type it;
      it.op      = op;
      it.lock_id = id;
      if (!calm && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do begin
         @(posedge clock);
      end while (req_stall);
      // keep the held list in step with the block
      if (op == locm_pkg::OP_ACQUIRE && held_ids.size() < StackDepth)
         held_ids.insert(held_ids.size(), id);
      else if (op == locm_pkg::OP_RELEASE && held_ids.size() != 0 && held_ids[$] == id)
         held_ids.delete(held_ids.size() - 1);
      if (op != OP_UNUSED) items_sent++;
      calm = (items_sent >= 300 && items_sent < 450);
   endtask

   // Nest a few acquires, query, then unwind with some noise mixed in.
   // Ordered nests only add edges that climb in rank, so no new cycle forms.
   task automatic run_nest(input bit ordered);
      int goal;
      int lo;
      int keep;
      int r;
      if (ordered) goal = $urandom_range(1, 6);
      else if ($urandom_range(0, 9) == 0) goal = $urandom_range(StackDepth - 1, StackDepth + 2);
      else goal = $urandom_range(1, 8);
      for (int i = 0; i < goal; i++) begin
         if ($urandom_range(0, 9) == 0) send_item(locm_pkg::OP_QUERY, IdW'($urandom));
         if (ordered) begin
            lo = (held_ids.size() == 0) ? 0 : lock_rank(held_ids[$]) + 1;
            if (lo > TOP_RANK) break;
            send_item(locm_pkg::OP_ACQUIRE, rank_to_lock($urandom_range(lo, TOP_RANK)));
         end else begin
            send_item(locm_pkg::OP_ACQUIRE, IdW'($urandom_range(0, NumLocks - 1)));
         end
      end
      send_item(locm_pkg::OP_QUERY, IdW'($urandom));
      keep = ($urandom_range(0, 4) == 0) ? $urandom_range(0, held_ids.size()) : 0;
      while (held_ids.size() > keep) begin
         r = $urandom_range(0, 99);
         if (r < 6) send_item(locm_pkg::OP_RELEASE, IdW'($urandom));
         else if (r < 9) send_item(OP_UNUSED, IdW'($urandom));
         else if (r < 12) send_item(locm_pkg::OP_QUERY, IdW'($urandom));
         if (held_ids.size() > keep) send_item(locm_pkg::OP_RELEASE, held_ids[$]);
      end
      if (held_ids.size() == 0 && $urandom_range(0, 3) == 0)
         send_item(locm_pkg::OP_RELEASE, IdW'($urandom));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: no root yet, empty release, unused opcode
      send_item(locm_pkg::OP_QUERY, 4'd15);
      send_item(locm_pkg::OP_RELEASE, 4'd5);
      send_item(OP_UNUSED, 4'd10);
      // last lock becomes the root; wrong release leaves the stack alone
      send_item(locm_pkg::OP_ACQUIRE, 4'd15);
      send_item(locm_pkg::OP_RELEASE, 4'd0);
      send_item(locm_pkg::OP_RELEASE, 4'd15);
      send_item(locm_pkg::OP_QUERY, 4'd0);
      // two-lock cycle that the root cannot reach
      send_item(locm_pkg::OP_ACQUIRE, 4'd0);
      send_item(locm_pkg::OP_ACQUIRE, 4'd1);
      send_item(locm_pkg::OP_RELEASE, 4'd1);
      send_item(locm_pkg::OP_RELEASE, 4'd0);
      send_item(locm_pkg::OP_ACQUIRE, 4'd1);
      send_item(locm_pkg::OP_ACQUIRE, 4'd0);
      send_item(locm_pkg::OP_QUERY, 4'd7);
      send_item(locm_pkg::OP_RELEASE, 4'd0);
      send_item(locm_pkg::OP_RELEASE, 4'd1);

      // Random: acyclic growth from the root first, then free ordering
      while (items_sent < DIRECTED_ITEMS + ORDERED_ITEMS) run_nest(1'b1);
      while (items_sent < TOTAL_ITEMS) run_nest(1'b0);
      req_valid <= 1'b0;

      // Drain, then give the block time for anything stray
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Timeout
   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
